### rtl/slp_pkg.sv
// Shared types, constants and the threshold level function for the sensor line parser.
package slp_pkg;

	// Defaults for the top-level parameters.
	localparam int LINE_LEN_DEF    = 128;
	localparam int QUEUE_DEPTH_DEF = 4;

	// Threshold register reset values.
	localparam logic signed [31:0] LOW_THR_RST  = 32'sd50;
	localparam logic signed [31:0] HIGH_THR_RST = 32'sd80;

	// Configuration register indexes.
	localparam logic [1:0] CFG_LOW  = 2'd0;
	localparam logic [1:0] CFG_HIGH = 2'd1;

	// Threshold level codes.
	localparam logic [1:0] LVL_GREEN  = 2'd0;
	localparam logic [1:0] LVL_YELLOW = 2'd1;
	localparam logic [1:0] LVL_RED    = 2'd2;

	// Byte classes produced by the front end.
	typedef enum logic [3:0] {
		TK_OTHER,
		TK_DIGIT,
		TK_SPACE,
		TK_PLUS,
		TK_MINUS,
		TK_T,
		TK_H,
		TK_G,
		TK_COLON,
		TK_NEWLINE
	} tok_kind_t;

	typedef struct packed {
		tok_kind_t  kind;
		logic [3:0] digit;
	} token_t;

	// Fill status of the token queue.
	typedef struct packed {
		logic empty;
		logic full;
	} q_stat_t;

	function automatic logic [1:0] level_of(input logic signed [31:0] v,
			input logic signed [31:0] lo, input logic signed [31:0] hi);
		logic [1:0] lvl;
		if (v < lo) begin
			lvl = LVL_GREEN;
		end else if (v < hi) begin
			lvl = LVL_YELLOW;
		end else begin
			lvl = LVL_RED;
		end
		return lvl;
	endfunction

endpackage

### rtl/slp_front.sv
// Front end: accepts received bytes, classifies them and pushes tokens into the queue.
module slp_front (
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic [7:0]            rx_byte,
	input  slp_pkg::q_stat_t      q_stat,
	output logic                  push,
	output slp_pkg::token_t       tok
);

	localparam logic [7:0] CH_CR = 8'h0D;

	logic is_cr;

	// Carriage returns are swallowed here and never reach the parser.
	assign is_cr    = (rx_byte == CH_CR);
	assign in_ready = !q_stat.full;
	assign push     = in_valid && in_ready && !is_cr;

	always_comb begin
		tok.digit = rx_byte[3:0];
		unique case (rx_byte) inside
			[8'h30:8'h39]:         tok.kind = slp_pkg::TK_DIGIT;
			[8'h09:8'h0D], 8'h20:  tok.kind = slp_pkg::TK_SPACE;
			8'h2B:                 tok.kind = slp_pkg::TK_PLUS;
			8'h2D:                 tok.kind = slp_pkg::TK_MINUS;
			8'h54:                 tok.kind = slp_pkg::TK_T;
			8'h48:                 tok.kind = slp_pkg::TK_H;
			8'h47:                 tok.kind = slp_pkg::TK_G;
			8'h3A:                 tok.kind = slp_pkg::TK_COLON;
			default:               tok.kind = slp_pkg::TK_OTHER;
		endcase
		// A line feed is also white space by the byte ranges above, so it is decided last.
		if (rx_byte == 8'h0A) begin
			tok.kind = slp_pkg::TK_NEWLINE;
		end
	end

endmodule

### rtl/slp_queue.sv
// Short token queue between the front end and the parser.
module slp_queue #(
	parameter int DEPTH = slp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  slp_pkg::token_t   wr_tok,
	input  logic              pop,
	output slp_pkg::token_t   rd_tok,
	output slp_pkg::q_stat_t  stat
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);

	slp_pkg::token_t slots_q [DEPTH];
	logic [AW-1:0]   wr_ptr_q;
	logic [AW-1:0]   rd_ptr_q;
	logic [CW-1:0]   cnt_q;

	assign stat.empty = (cnt_q == '0);
	assign stat.full  = (cnt_q == CW'(DEPTH));
	assign rd_tok     = slots_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_tok;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### rtl/slp_back.sv
// Back end: line parser state machine, held values and the result register.
module slp_back #(
	parameter int LINE_LEN = slp_pkg::LINE_LEN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  slp_pkg::q_stat_t    q_stat,
	input  slp_pkg::token_t     tok,
	output logic                pop,
	input  logic signed [31:0]  low_thr,
	input  logic signed [31:0]  high_thr,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  temperature,
	output logic signed [31:0]  humidity,
	output logic signed [31:0]  gas_level,
	output logic [1:0]          temperature_class,
	output logic [1:0]          humidity_class,
	output logic [1:0]          gas_class,
	output logic [1:0]          fields_matched
);

	localparam int          CW      = $clog2(LINE_LEN);
	localparam logic [31:0] MAG_CAP = 32'h8000_0000;
	localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

	typedef enum logic [3:0] {
		PH_T, PH_TC, PH_I0, PH_H, PH_HC, PH_I1, PH_G, PH_GC, PH_I2,
		PH_STOP0, PH_STOP1, PH_STOP2, PH_DONE
	} phase_t;

	phase_t         phase_q, phase_d;
	logic [CW-1:0]  cnt_q, cnt_d;
	logic [31:0]    acc_q, acc_d;
	logic           neg_q, neg_d;
	logic           dig_q, dig_d;
	logic           sgn_q, sgn_d;
	logic [31:0]    pend0_q, pend0_d;
	logic [31:0]    pend1_q, pend1_d;
	logic [31:0]    held0_q, held0_d;
	logic [31:0]    held1_q, held1_d;
	logic [31:0]    held2_q, held2_d;
	logic [1:0]     matched_q, matched_d;
	logic           out_valid_q, out_valid_d;

	logic           is_int;
	logic           is_lf;
	logic           is_ws;
	logic           out_free;
	logic           fin_now;
	logic [35:0]    acc_ext;
	logic [35:0]    acc_x10;
	logic [31:0]    acc_dig;
	logic [31:0]    fin_val;
	logic [1:0]     base_n;
	logic [1:0]     n;

	assign is_int   = (phase_q == PH_I0) || (phase_q == PH_I1) || (phase_q == PH_I2);
	assign is_lf    = (tok.kind == slp_pkg::TK_NEWLINE);
	assign is_ws    = (tok.kind == slp_pkg::TK_SPACE);
	assign out_free = !out_valid_q || out_ready;
	// A line feed waits in the queue until the result register can take it.
	assign pop      = !q_stat.empty && (!is_lf || out_free);
	assign fin_now  = is_int && dig_q;

	// Decimal step: acc * 10 + digit, clipped at the magnitude of the most negative value.
	assign acc_ext = {4'd0, acc_q};
	assign acc_x10 = (acc_ext << 3) + (acc_ext << 1) + {32'd0, tok.digit};
	assign acc_dig = (acc_x10 > {4'd0, MAG_CAP}) ? MAG_CAP : acc_x10[31:0];
	assign fin_val = neg_q ? (32'd0 - acc_q) : (acc_q[31] ? POS_MAX : acc_q);

	// Fields completed so far, before any number still in progress.
	always_comb begin
		unique case (phase_q)
			PH_H, PH_HC, PH_I1, PH_STOP1: base_n = 2'd1;
			PH_G, PH_GC, PH_I2, PH_STOP2: base_n = 2'd2;
			PH_DONE:                      base_n = 2'd3;
			default:                      base_n = 2'd0;
		endcase
	end

	assign n = base_n + {1'b0, fin_now};

	always_comb begin
		phase_d     = phase_q;
		cnt_d       = cnt_q;
		acc_d       = acc_q;
		neg_d       = neg_q;
		dig_d       = dig_q;
		sgn_d       = sgn_q;
		pend0_d     = pend0_q;
		pend1_d     = pend1_q;
		held0_d     = held0_q;
		held1_d     = held1_q;
		held2_d     = held2_q;
		matched_d   = matched_q;
		out_valid_d = out_valid_q && !out_ready;

		if (pop && is_lf) begin
			// End of line: commit the leading fields that matched and publish.
			if (n >= 2'd1) begin
				held0_d = (phase_q == PH_I0) ? fin_val : pend0_q;
			end
			if (n >= 2'd2) begin
				held1_d = (phase_q == PH_I1) ? fin_val : pend1_q;
			end
			if (n == 2'd3) begin
				held2_d = (phase_q == PH_I2) ? fin_val : acc_q;
			end
			matched_d   = n;
			out_valid_d = 1'b1;
			phase_d     = PH_T;
			cnt_d       = '0;
			acc_d       = '0;
			neg_d       = 1'b0;
			dig_d       = 1'b0;
			sgn_d       = 1'b0;
		end else if (pop) begin
			unique case (phase_q) inside
				PH_I0, PH_I1, PH_I2: begin
					if (tok.kind == slp_pkg::TK_DIGIT) begin
						acc_d = acc_dig;
						dig_d = 1'b1;
					end else if (!dig_q) begin
						if (!sgn_q && is_ws) begin
							// Leading white space before the number is skipped.
						end else if (!sgn_q && (tok.kind == slp_pkg::TK_PLUS ||
								tok.kind == slp_pkg::TK_MINUS)) begin
							sgn_d = 1'b1;
							neg_d = (tok.kind == slp_pkg::TK_MINUS);
						end else begin
							unique case (phase_q)
								PH_I0:   phase_d = PH_STOP0;
								PH_I1:   phase_d = PH_STOP1;
								default: phase_d = PH_STOP2;
							endcase
						end
					end else begin
						// The byte ends the number; after temperature or humidity it is then matched against the next letter.
						neg_d = 1'b0;
						dig_d = 1'b0;
						sgn_d = 1'b0;
						unique case (phase_q)
							PH_I0: begin
								pend0_d = fin_val;
								acc_d   = '0;
								phase_d = is_ws ? PH_H :
									((tok.kind == slp_pkg::TK_H) ? PH_HC : PH_STOP1);
							end
							PH_I1: begin
								pend1_d = fin_val;
								acc_d   = '0;
								phase_d = is_ws ? PH_G :
									((tok.kind == slp_pkg::TK_G) ? PH_GC : PH_STOP2);
							end
							default: begin
								acc_d   = fin_val;
								phase_d = PH_DONE;
							end
						endcase
					end
				end
				PH_T: begin
					phase_d = (tok.kind == slp_pkg::TK_T) ? PH_TC : PH_STOP0;
				end
				PH_TC: begin
					phase_d = (tok.kind == slp_pkg::TK_COLON) ? PH_I0 : PH_STOP0;
				end
				PH_H: begin
					if (!is_ws) begin
						phase_d = (tok.kind == slp_pkg::TK_H) ? PH_HC : PH_STOP1;
					end
				end
				PH_HC: begin
					phase_d = (tok.kind == slp_pkg::TK_COLON) ? PH_I1 : PH_STOP1;
				end
				PH_G: begin
					if (!is_ws) begin
						phase_d = (tok.kind == slp_pkg::TK_G) ? PH_GC : PH_STOP2;
					end
				end
				PH_GC: begin
					phase_d = (tok.kind == slp_pkg::TK_COLON) ? PH_I2 : PH_STOP2;
				end
				default: begin
					// Stopped or finished: the rest of the line is ignored.
				end
			endcase

			// A line that reaches LINE_LEN tokens without a line feed starts the parse over.
			if (cnt_q == CW'(LINE_LEN - 1)) begin
				phase_d = PH_T;
				cnt_d   = '0;
				acc_d   = '0;
				neg_d   = 1'b0;
				dig_d   = 1'b0;
				sgn_d   = 1'b0;
			end else begin
				cnt_d = cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_T;
			cnt_q       <= '0;
			acc_q       <= '0;
			neg_q       <= 1'b0;
			dig_q       <= 1'b0;
			sgn_q       <= 1'b0;
			pend0_q     <= '0;
			pend1_q     <= '0;
			held0_q     <= '0;
			held1_q     <= '0;
			held2_q     <= '0;
			matched_q   <= '0;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			cnt_q       <= cnt_d;
			acc_q       <= acc_d;
			neg_q       <= neg_d;
			dig_q       <= dig_d;
			sgn_q       <= sgn_d;
			pend0_q     <= pend0_d;
			pend1_q     <= pend1_d;
			held0_q     <= held0_d;
			held1_q     <= held1_d;
			held2_q     <= held2_d;
			matched_q   <= matched_d;
			out_valid_q <= out_valid_d;
		end
	end

	assign out_valid         = out_valid_q;
	assign temperature       = held0_q;
	assign humidity          = held1_q;
	assign gas_level         = held2_q;
	assign fields_matched    = matched_q;
	assign temperature_class = slp_pkg::level_of(held0_q, low_thr, high_thr);
	assign humidity_class    = slp_pkg::level_of(held1_q, low_thr, high_thr);
	assign gas_class         = slp_pkg::level_of(held2_q, low_thr, high_thr);

endmodule

### rtl/sensor_line_parser.sv
// Top level of the sensor line parser: byte front end, token queue, parser and thresholds.
//
//   channel   direction  handshake              payload
//   in        sink       in_valid / in_ready    rx_byte
//   out       source     out_valid / out_ready  temperature, humidity, gas_level,
//                                               *_class, fields_matched
//   cfg       sink       cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One byte word is taken per cycle while the token queue is not full. A byte other than CR is written
// into the token queue at the edge that accepts it and the parser takes it from there; a
// line feed word is registered into the result register on out when the parser consumes it.
// Reset clears the parse state and held values and loads the threshold reset values at once; no clearing pass.
// When the result register is full and not taken, a line feed waits in the queue;
// the input side keeps taking words until the QUEUE_DEPTH-entry queue is full.
// cfg_ready is always high.
module sensor_line_parser #(
	parameter int LINE_LEN    = slp_pkg::LINE_LEN_DEF,
	parameter int QUEUE_DEPTH = slp_pkg::QUEUE_DEPTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [7:0]          rx_byte,
	output logic                out_valid,
	input  logic                out_ready,
	output logic signed [31:0]  temperature,
	output logic signed [31:0]  humidity,
	output logic signed [31:0]  gas_level,
	output logic [1:0]          temperature_class,
	output logic [1:0]          humidity_class,
	output logic [1:0]          gas_class,
	output logic [1:0]          fields_matched,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [1:0]          cfg_index,
	input  logic [31:0]         cfg_data
);

	slp_pkg::q_stat_t   q_stat;
	slp_pkg::token_t    push_tok;
	slp_pkg::token_t    pop_tok;
	logic               push;
	logic               pop;
	logic signed [31:0] low_thr_q;
	logic signed [31:0] high_thr_q;

	// Threshold registers. Writes to indexes past the last register are dropped.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_thr_q  <= slp_pkg::LOW_THR_RST;
			high_thr_q <= slp_pkg::HIGH_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				slp_pkg::CFG_LOW:  low_thr_q  <= cfg_data;
				slp_pkg::CFG_HIGH: high_thr_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// The front end classifies each byte into a token and drops carriage returns.
	slp_front u_front (
		.in_valid (in_valid),
		.in_ready (in_ready),
		.rx_byte  (rx_byte),
		.q_stat   (q_stat),
		.push     (push),
		.tok      (push_tok)
	);

	// The queue decouples byte intake from the parser, which stalls only on line feeds.
	slp_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_tok (push_tok),
		.pop    (pop),
		.rd_tok (pop_tok),
		.stat   (q_stat)
	);

	// The parser walks the line pattern one token per cycle unless stalled; it owns the result register.
	slp_back #(
		.LINE_LEN (LINE_LEN)
	) u_back (
		.clk               (clk),
		.arst_n            (arst_n),
		.q_stat            (q_stat),
		.tok               (pop_tok),
		.pop               (pop),
		.low_thr           (low_thr_q),
		.high_thr          (high_thr_q),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.temperature       (temperature),
		.humidity          (humidity),
		.gas_level         (gas_level),
		.temperature_class (temperature_class),
		.humidity_class    (humidity_class),
		.gas_class         (gas_class),
		.fields_matched    (fields_matched)
	);

endmodule

### rtl/slp_checker.sv
// Port-level checker for the sensor line parser and its bind to the top level.
module slp_checker (
	input logic                clk,
	input logic                arst_n,
	input logic                out_valid,
	input logic                out_ready,
	input logic signed [31:0]  temperature,
	input logic signed [31:0]  humidity,
	input logic signed [31:0]  gas_level,
	input logic [1:0]          temperature_class,
	input logic [1:0]          humidity_class,
	input logic [1:0]          gas_class,
	input logic [1:0]          fields_matched,
	input logic                cfg_valid,
	input logic                cfg_ready,
	input logic [1:0]          cfg_index,
	input logic [31:0]         cfg_data
);

	logic signed [31:0] lo_q;
	logic signed [31:0] hi_q;

	// Shadow copy of the thresholds as seen on the configuration port.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_q <= slp_pkg::LOW_THR_RST;
			hi_q <= slp_pkg::HIGH_THR_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == slp_pkg::CFG_LOW) begin
				lo_q <= cfg_data;
			end
			if (cfg_index == slp_pkg::CFG_HIGH) begin
				hi_q <= cfg_data;
			end
		end
	end

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(temperature) && $stable(humidity) &&
			$stable(gas_level) && $stable(fields_matched))
		else $error("result word changed while stalled");

	a_temp_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> temperature_class == slp_pkg::level_of(temperature, lo_q, hi_q))
		else $error("temperature level disagrees with thresholds");

	a_hum_gas_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> humidity_class == slp_pkg::level_of(humidity, lo_q, hi_q) &&
			gas_class == slp_pkg::level_of(gas_level, lo_q, hi_q))
		else $error("humidity or gas level disagrees with thresholds");

endmodule

bind sensor_line_parser slp_checker u_slp_checker (.*);
